FILE: rtl/core/sqlts_pkg.sv
// ----------------------------------------------------------------------------
// sqlts_pkg
// Shared types, token codes, keyword tables and helpers for the SQL scanner.
// ----------------------------------------------------------------------------
package sqlts_pkg;

    localparam int unsigned TEXT_BYTES = 65536;
    localparam logic [15:0] OFFSET_CAP =
        (TEXT_BYTES - 1 < 65535) ? 16'(TEXT_BYTES - 1) : 16'hFFFF;
    localparam logic [15:0] SAT16 = 16'hFFFF;

    localparam int unsigned KW_COUNT = 29;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [5:0] KIND_EOF     = 6'd0;
    localparam logic [5:0] KIND_IDENT   = 6'd1;
    localparam logic [5:0] KIND_NUMBER  = 6'd2;
    localparam logic [5:0] KIND_STRING  = 6'd3;
    localparam logic [5:0] KIND_LPAREN  = 6'd4;
    localparam logic [5:0] KIND_RPAREN  = 6'd5;
    localparam logic [5:0] KIND_COMMA   = 6'd6;
    localparam logic [5:0] KIND_SEMI    = 6'd7;
    localparam logic [5:0] KIND_STAR    = 6'd8;
    localparam logic [5:0] KIND_EQUAL   = 6'd9;
    localparam logic [5:0] KIND_INVALID = 6'd10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Spellings are right-justified in 80 bits, zero padded on the left.
    localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
        "CREATE", "TABLE", "INSERT", "INTO", "VALUES", "SELECT", "FROM", "WHERE",
        "GROUP", "BY", "COUNT", "SUM", "MIN", "MAX", "AVG", "HAVING", "IN", "AS",
        "WITH", "OVER", "PARTITION", "ORDER", "RANK", {"ROW_", "NUMBER"}, "ASC",
        "DESC", "INT", "INTEGER", "VARCHAR"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd2, 4'd5, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd6, 4'd2, 4'd2, 4'd4, 4'd4, 4'd9, 4'd5, 4'd4, 4'd10,
        4'd3, 4'd4, 4'd3, 4'd7, 4'd7
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
        6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd37, 6'd38
    };

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NUMBER = 4'b0010,
        MODE_WORD   = 4'b0100,
        MODE_STRING = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] offset;
        logic [15:0] length;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] cap);
        return (v < cap) ? v + 16'd1 : cap;
    endfunction

    // Character at position p of keyword k, zero past its end.
    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] p);
        logic [7:0] ch;
        logic [3:0] pos;
        ch  = CH_NUL;
        pos = '0;
        if (p < KW_LEN[k]) begin
            pos = KW_LEN[k] - 4'd1 - p;
            ch  = KW_TEXT[k][{pos, 3'b000} +: 8];
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/sql_token_scanner.sv
// ----------------------------------------------------------------------------
// sql_token_scanner: streaming SQL lexer, one text byte per transfer.
// The byte that ends a token is held in the input register; the token then enters the output queue.
// Throughput: one byte per cycle while o_stall is low; a byte that ends two tokens needs two output slots.
// Synchronous active-low reset returns to line 1, column 1, offset 0, queue empty.
// ----------------------------------------------------------------------------
module sql_token_scanner import sqlts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [15:0] o_token_offset,
    output logic [15:0] o_token_length,
    output logic        o_last_result
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       room;
    logic       fire;
    t_push      push;
    t_token     head;

    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
            r_in_end  <= i_end_of_text;
        end
    end

    sqlts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_byte),
        .i_end   (r_in_end),
        .o_push  (push)
    );

    sqlts_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_valid && !i_stall),
        .o_valid (o_valid),
        .o_token (head),
        .o_room  (room)
    );

    assign o_token_kind   = head.kind;
    assign o_token_line   = head.line;
    assign o_token_column = head.column;
    assign o_token_offset = head.offset;
    assign o_token_length = head.length;
    assign o_last_result  = head.last;

endmodule

FILE: rtl/core/sqlts_kw_match.sv
// ----------------------------------------------------------------------------
// sqlts_kw_match
// Keyword candidate mask update for one word byte, and word kind resolution.
// ----------------------------------------------------------------------------
module sqlts_kw_match import sqlts_pkg::*; (
    input  logic [KW_COUNT-1:0] i_mask,
    input  logic [15:0]         i_pos,
    input  logic [7:0]          i_char,
    output logic [KW_COUNT-1:0] o_mask,
    input  logic [KW_COUNT-1:0] i_word_mask,
    input  logic [15:0]         i_word_len,
    output logic [5:0]          o_word_kind
);

    logic [7:0] up;
    logic       pos_ok;

    assign up     = (i_char >= "a" && i_char <= "z") ? i_char - 8'd32 : i_char;
    assign pos_ok = (i_pos[15:4] == 12'd0);

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            o_mask[k] = i_mask[k] && pos_ok && (kw_char(5'(k), i_pos[3:0]) == up);
        end
    end

    // Lowest matching index wins.
    always_comb begin
        o_word_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (i_word_mask[k] && i_word_len == {12'd0, KW_LEN[k]}) begin
                o_word_kind = KW_KIND[k];
            end
        end
    end

endmodule

FILE: rtl/core/sqlts_scan.sv
// ----------------------------------------------------------------------------
// sqlts_scan
// Scanner state and per-byte token logic; produces up to two tokens per byte.
// ----------------------------------------------------------------------------
module sqlts_scan import sqlts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output t_push      o_push
);

    t_mode               r_mode, n_mode;
    logic [15:0]         r_line, n_line;
    logic [15:0]         r_col, n_col;
    logic [15:0]         r_off, n_off;
    logic [15:0]         r_start_col, n_start_col;
    logic [15:0]         r_start_off, n_start_off;
    logic [15:0]         r_count, n_count;
    logic [KW_COUNT-1:0] r_mask, n_mask;

    logic                is_end, is_digit, is_alpha, is_wordc, is_space, is_quote;
    logic [5:0]          sym_kind;
    logic [15:0]         adv_line, adv_col, adv_off;
    logic                kw_start;
    logic [KW_COUNT-1:0] kw_mask_in, kw_mask_out;
    logic [15:0]         kw_pos;
    logic [5:0]          word_kind;
    logic                pend_valid;
    t_token              pend_tok, eof_tok, sym_tok;
    t_token              t0, t1;
    logic [1:0]          nres;

    assign is_end   = i_end || (i_char == CH_NUL);
    assign is_digit = (i_char >= "0") && (i_char <= "9");
    assign is_alpha = ((i_char >= "A") && (i_char <= "Z")) ||
                      ((i_char >= "a") && (i_char <= "z"));
    assign is_wordc = is_alpha || is_digit || (i_char == CH_UNDER);
    assign is_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign is_quote = (i_char == CH_QUOTE);

    always_comb begin
        case (i_char)
            CH_LPAREN: sym_kind = KIND_LPAREN;
            CH_RPAREN: sym_kind = KIND_RPAREN;
            CH_COMMA:  sym_kind = KIND_COMMA;
            CH_SEMI:   sym_kind = KIND_SEMI;
            CH_STAR:   sym_kind = KIND_STAR;
            CH_EQUAL:  sym_kind = KIND_EQUAL;
            default:   sym_kind = KIND_INVALID;
        endcase
    end

    assign adv_line = (i_char == CH_NL) ? sat_inc(r_line, SAT16) : r_line;
    assign adv_col  = (i_char == CH_NL) ? 16'd1 : sat_inc(r_col, SAT16);
    assign adv_off  = sat_inc(r_off, OFFSET_CAP);

    assign kw_start   = !((r_mode == MODE_WORD) && is_wordc);
    assign kw_mask_in = kw_start ? '1 : r_mask;
    assign kw_pos     = kw_start ? 16'd0 : r_count;

    sqlts_kw_match u_kw_match (
        .i_mask      (kw_mask_in),
        .i_pos       (kw_pos),
        .i_char      (i_char),
        .o_mask      (kw_mask_out),
        .i_word_mask (r_mask),
        .i_word_len  (r_count),
        .o_word_kind (word_kind)
    );

    assign pend_valid = (r_mode != MODE_IDLE);

    always_comb begin
        pend_tok.kind   = KIND_STRING;
        if (r_mode == MODE_NUMBER) pend_tok.kind = KIND_NUMBER;
        if (r_mode == MODE_WORD)   pend_tok.kind = word_kind;
        pend_tok.line   = r_line;
        pend_tok.column = r_start_col;
        pend_tok.offset = r_start_off;
        pend_tok.length = r_count;
        pend_tok.last   = 1'b0;

        eof_tok.kind    = KIND_EOF;
        eof_tok.line    = r_line;
        eof_tok.column  = r_col;
        eof_tok.offset  = r_off;
        eof_tok.length  = 16'd0;
        eof_tok.last    = 1'b0;

        sym_tok.kind    = sym_kind;
        sym_tok.line    = adv_line;
        sym_tok.column  = r_col;
        sym_tok.offset  = r_off;
        sym_tok.length  = 16'd1;
        sym_tok.last    = 1'b0;
    end

    always_comb begin
        n_mode      = r_mode;
        n_line      = r_line;
        n_col       = r_col;
        n_off       = r_off;
        n_start_col = r_start_col;
        n_start_off = r_start_off;
        n_count     = r_count;
        n_mask      = r_mask;
        t0          = pend_tok;
        t1          = eof_tok;
        nres        = 2'd0;

        if (is_end) begin
            if (pend_valid) begin
                nres = 2'd2;
            end else begin
                t0   = eof_tok;
                nres = 2'd1;
            end
            n_mode      = MODE_IDLE;
            n_line      = 16'd1;
            n_col       = 16'd1;
            n_off       = 16'd0;
            n_start_col = 16'd1;
            n_start_off = 16'd0;
            n_count     = 16'd0;
            n_mask      = '1;
        end else if (r_mode == MODE_STRING) begin
            if (is_quote) begin
                nres   = 2'd1;
                n_mode = MODE_IDLE;
            end else begin
                n_count = sat_inc(r_count, SAT16);
            end
            n_line = adv_line;
            n_col  = adv_col;
            n_off  = adv_off;
        end else if ((r_mode == MODE_NUMBER) && is_digit) begin
            n_count = sat_inc(r_count, SAT16);
            n_line  = adv_line;
            n_col   = adv_col;
            n_off   = adv_off;
        end else if ((r_mode == MODE_WORD) && is_wordc) begin
            n_mask  = kw_mask_out;
            n_count = sat_inc(r_count, SAT16);
            n_line  = adv_line;
            n_col   = adv_col;
            n_off   = adv_off;
        end else begin
            nres   = pend_valid ? 2'd1 : 2'd0;
            n_mode = MODE_IDLE;
            n_line = adv_line;
            n_col  = adv_col;
            n_off  = adv_off;
            if (!is_space) begin
                n_start_col = r_col;
                n_start_off = r_off;
                if (is_digit) begin
                    n_mode  = MODE_NUMBER;
                    n_count = 16'd1;
                end else if (is_alpha || (i_char == CH_UNDER)) begin
                    n_mode  = MODE_WORD;
                    n_mask  = kw_mask_out;
                    n_count = 16'd1;
                end else if (is_quote) begin
                    n_mode      = MODE_STRING;
                    n_count     = 16'd0;
                    n_start_off = adv_off;
                end else if (pend_valid) begin
                    t1   = sym_tok;
                    nres = 2'd2;
                end else begin
                    t0   = sym_tok;
                    nres = 2'd1;
                end
            end
        end

        if (nres == 2'd1) t0.last = 1'b1;
        if (nres == 2'd2) t1.last = 1'b1;
    end

    assign o_push.count = i_fire ? nres : 2'd0;
    assign o_push.tok0  = t0;
    assign o_push.tok1  = t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_line      <= 16'd1;
            r_col       <= 16'd1;
            r_off       <= 16'd0;
            r_start_col <= 16'd1;
            r_start_off <= 16'd0;
            r_count     <= 16'd0;
            r_mask      <= '1;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_line      <= n_line;
            r_col       <= n_col;
            r_off       <= n_off;
            r_start_col <= n_start_col;
            r_start_off <= n_start_off;
            r_count     <= n_count;
            r_mask      <= n_mask;
        end
    end

endmodule

FILE: rtl/core/sqlts_out_queue.sv
// ----------------------------------------------------------------------------
// sqlts_out_queue
// Small token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module sqlts_out_queue import sqlts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_valid,
    output t_token o_token,
    output logic   o_room
);

    t_token               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic [Q_PTR_W-1:0]   wr_next;

    assign wr_next = r_wr + 1'b1;
    assign o_valid = (r_cnt != '0);
    assign o_token = r_mem[r_rd];
    assign o_room  = (r_cnt <= Q_CNT_W'(Q_DEPTH - 2));

    assign n_wr  = r_wr + Q_PTR_W'(i_push.count);
    assign n_rd  = r_rd + Q_PTR_W'(i_pop);
    assign n_cnt = r_cnt + Q_CNT_W'(i_push.count) - Q_CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.count == 2'd2) r_mem[wr_next] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/sqlts_checker.sv
// ----------------------------------------------------------------------------
// sqlts_checker
// Port-level checks for the SQL token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module sqlts_checker import sqlts_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_token_kind,
    input logic [15:0] o_token_length,
    input logic        o_last_result
);

    // held output transfer keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) && $stable(o_token_length))
        else $error("stalled output transfer changed");

    // input backpressure only while results are waiting
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == KIND_EOF) |-> (o_token_length == 16'd0) && o_last_result)
        else $error("bad end-of-file token");

    a_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind >= KIND_LPAREN) && (o_token_kind <= KIND_INVALID)
        |-> (o_token_length == 16'd1) && o_last_result)
        else $error("bad symbol token");

endmodule

bind sql_token_scanner sqlts_checker u_sqlts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_token_kind   (o_token_kind),
    .o_token_length (o_token_length),
    .o_last_result  (o_last_result)
);

FILE: tb/sql_token_scanner_test.sv
// ----------------------------------------------------------------------------
// sql_token_scanner_test
// Feeds text bytes to the SQL scanner and checks every emitted token against
// an in-bench scanner model: symbols, invalid bytes, whitespace, keywords,
// identifiers, numbers, strings, end of input, and random SQL-like text under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sql_token_scanner_test
    import sqlts_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] POS_CAP =
        (TEXT_BYTES - 1 < 65535) ? 16'(TEXT_BYTES - 1) : 16'hFFFF;
    localparam int KW_ALIAS = 27;  // INTEGER shares the code of INT

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_text_byte = CH_NUL;
    logic        i_end_of_text = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_token_kind;
    logic [15:0] o_token_line;
    logic [15:0] o_token_column;
    logic [15:0] o_token_offset;
    logic [15:0] o_token_length;
    logic        o_last_result;

    sql_token_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_last_result  (o_last_result)
    );

    string kw_spell [KW_COUNT] = '{
        "CREATE", "TABLE", "INSERT", "INTO", "VALUES", "SELECT", "FROM", "WHERE",
        "GROUP", "BY", "COUNT", "SUM", "MIN", "MAX", "AVG", "HAVING", "IN", "AS",
        "WITH", "OVER", "PARTITION", "ORDER", "RANK", {"ROW_", "NUMBER"}, "ASC",
        "DESC", "INT", "INTEGER", "VARCHAR"
    };

    t_mode                scan_state = MODE_IDLE;
    logic [15:0]          cur_line = 16'd1;
    logic [15:0]          cur_col = 16'd1;
    logic [15:0]          cur_off = 16'd0;
    logic [15:0]          tok_col = 16'd1;
    logic [15:0]          tok_off = 16'd0;
    logic [15:0]          tok_len = 16'd0;
    logic [KW_COUNT-1:0]  kw_alive = '1;

    t_token      step_out [2];
    int          step_n;
    t_token      expected_tokens [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sent_items = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- scanner model ----------------

    function automatic logic [15:0] bump(input logic [15:0] v, input logic [15:0] cap);
        return (v == cap) ? v : v + 16'd1;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    task automatic reset_scan();
        scan_state = MODE_IDLE;
        cur_line   = 16'd1;
        cur_col    = 16'd1;
        cur_off    = 16'd0;
        tok_col    = 16'd1;
        tok_off    = 16'd0;
        tok_len    = 16'd0;
        kw_alive   = '1;
    endtask

    task automatic step_position(input logic [7:0] c);
        if (c == CH_NL) begin
            cur_line = bump(cur_line, COUNT_MAX);
            cur_col  = 16'd1;
        end else begin
            cur_col = bump(cur_col, COUNT_MAX);
        end
        cur_off = bump(cur_off, POS_CAP);
    endtask

    task automatic add_token(input logic [5:0] kind, input logic [15:0] line,
                             input logic [15:0] col, input logic [15:0] off,
                             input logic [15:0] len);
        step_out[step_n] = '{kind, line, col, off, len, 1'b0};
        step_n++;
    endtask

    task automatic match_keyword_char(input logic [7:0] c);
        logic [7:0] up;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_alive[k] && (int'(tok_len) >= kw_spell[k].len() ||
                                kw_spell[k][int'(tok_len)] != up))
                kw_alive[k] = 1'b0;
        end
        tok_len = bump(tok_len, COUNT_MAX);
    endtask

    function automatic logic [5:0] word_kind();
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_alive[k] && kw_spell[k].len() == int'(tok_len))
                return (k < KW_ALIAS) ? KIND_INVALID + 6'(k + 1) : KIND_INVALID + 6'(k);
        end
        return KIND_IDENT;
    endfunction

    task automatic flush_pending();
        logic [5:0] kind;
        case (scan_state)
            MODE_NUMBER: kind = KIND_NUMBER;
            MODE_WORD:   kind = word_kind();
            MODE_STRING: kind = KIND_STRING;
            default:     return;
        endcase
        scan_state = MODE_IDLE;
        add_token(kind, cur_line, tok_col, tok_off, tok_len);
    endtask

    task automatic scan_between(input logic [7:0] c);
        logic [5:0] kind;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            step_position(c);
            return;
        end
        case (c)
            CH_LPAREN: kind = KIND_LPAREN;
            CH_RPAREN: kind = KIND_RPAREN;
            CH_COMMA:  kind = KIND_COMMA;
            CH_SEMI:   kind = KIND_SEMI;
            CH_STAR:   kind = KIND_STAR;
            CH_EQUAL:  kind = KIND_EQUAL;
            default:   kind = KIND_INVALID;
        endcase
        tok_col = cur_col;
        tok_off = cur_off;
        if (is_digit(c)) begin
            scan_state = MODE_NUMBER;
            tok_len = 16'd1;
            step_position(c);
        end else if (is_letter(c) || c == CH_UNDER) begin
            scan_state = MODE_WORD;
            tok_len = 16'd0;
            kw_alive = '1;
            match_keyword_char(c);
            step_position(c);
        end else if (c == CH_QUOTE) begin
            scan_state = MODE_STRING;
            tok_len = 16'd0;
            step_position(c);
            tok_off = cur_off;
        end else begin
            step_position(c);
            add_token(kind, cur_line, tok_col, tok_off, 16'd1);
        end
    endtask

    task automatic predict_tokens(input logic [7:0] c, input logic eot);
        step_n = 0;
        if (eot || c == CH_NUL) begin
            flush_pending();
            add_token(KIND_EOF, cur_line, cur_col, cur_off, 16'd0);
            reset_scan();
        end else if (scan_state == MODE_STRING) begin
            if (c == CH_QUOTE)
                flush_pending();
            else
                tok_len = bump(tok_len, COUNT_MAX);
            step_position(c);
        end else if (scan_state == MODE_NUMBER && is_digit(c)) begin
            tok_len = bump(tok_len, COUNT_MAX);
            step_position(c);
        end else if (scan_state == MODE_WORD && is_word_char(c)) begin
            match_keyword_char(c);
            step_position(c);
        end else begin
            flush_pending();
            scan_between(c);
        end
        for (int i = 0; i < step_n; i++) begin
            if (i == step_n - 1)
                step_out[i].last = 1'b1;
            expected_tokens.insert(expected_tokens.size(), step_out[i]);
        end
    endtask

    // ---------------- transfer and checking ----------------

    task automatic send_byte(input logic [7:0] c, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
        predict_tokens(c, eot);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic drain_tokens();
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        i_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        got = {o_token_kind, o_token_line, o_token_column, o_token_offset,
               o_token_length, o_last_result};
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display(
                        "unexpected token kind %0d line %0d col %0d off %0d len %0d last %0d",
                        got.kind, got.line, got.column, got.offset, got.length, got.last);
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("token mismatch");
                        $display("expected kind %0d line %0d col %0d off %0d len %0d last %0d",
                                 want.kind, want.line, want.column, want.offset, want.length,
                                 want.last);
                        $display("     got kind %0d line %0d col %0d off %0d len %0d last %0d",
                                 got.kind, got.line, got.column, got.offset, got.length,
                                 got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sql_token_scanner test failed");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_symbols_and_invalid();
        send_text("(),;*=");
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain_tokens();
    endtask

    task automatic test_runs_and_end();
        send_text("Integer 42)'a\nb'");
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_NUL, 1'b0);
        drain_tokens();
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1))
            return ch + 8'd32;
        return ch;
    endfunction

    function automatic logic [7:0] random_word_char();
        case ($urandom_range(0, 3))
            0:       return "0" + 8'($urandom_range(0, 9));
            1:       return CH_UNDER;
            default: return mixed_case("A" + 8'($urandom_range(0, 25)));
        endcase
    endfunction

    task automatic send_random_fragment();
        int unsigned pick;
        int unsigned k;
        int unsigned n;
        logic [7:0]  ch;
        logic [7:0]  blanks [6];
        logic [7:0]  symbols [6];
        blanks  = '{CH_SPACE, CH_TAB, CH_NL, 8'h0B, 8'h0C, CH_CR};
        symbols = '{CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI, CH_STAR, CH_EQUAL};
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            k = $urandom_range(0, KW_COUNT - 1);
            n = kw_spell[k].len();
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(1, n);
            for (int i = 0; i < n; i++)
                send_byte(mixed_case(kw_spell[k][i]), 1'b0);
            if ($urandom_range(0, 6) == 0)
                send_byte(random_word_char(), 1'b0);
        end else if (pick < 45) begin
            ch = $urandom_range(0, 4) == 0 ? CH_UNDER
                                            : mixed_case("A" + 8'($urandom_range(0, 25)));
            send_byte(ch, 1'b0);
            n = $urandom_range(0, 7);
            repeat (n) send_byte(random_word_char(), 1'b0);
        end else if (pick < 55) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
        end else if (pick < 65) begin
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) begin
                ch = 8'($urandom_range(1, 255));
                send_byte(ch == CH_QUOTE ? CH_NL : ch, 1'b0);
            end
            if ($urandom_range(0, 9) != 0)
                send_byte(CH_QUOTE, 1'b0);
        end else if (pick < 80) begin
            send_byte(symbols[$urandom_range(0, 5)], 1'b0);
        end else if (pick < 90) begin
            send_byte(blanks[$urandom_range(0, 5)], 1'b0);
        end else if (pick < 96) begin
            send_byte(8'($urandom_range(1, 255)), 1'b0);
        end else if (pick < 98) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_byte(CH_NUL, 1'b0);
        end
        if ($urandom_range(0, 9) < 7)
            send_byte(blanks[$urandom_range(0, 5)], 1'b0);
    endtask

    task automatic test_random_sql(input int unsigned count);
        int unsigned stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
            send_random_fragment();
        drain_tokens();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 20;
        stall_pct     = 85;
        test_symbols_and_invalid();
        test_runs_and_end();
        test_random_sql(170);

        send_idle_pct = 85;
        stall_pct     = 20;
        test_random_sql(170);

        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_sql(180);

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("sql_token_scanner test passed");
        else
            $display("sql_token_scanner test failed");
        $finish;
    end

endmodule
